// ===== src/prl_pkg.sv =====
// ----------------------------------------------------------------------------
// prl_pkg
// shared constants and types for the page replacement frame table
// ----------------------------------------------------------------------------
package prl_pkg;

  localparam int FRAMES    = 8;
  localparam int IDX_W     = $clog2(FRAMES);
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int PAGE_W    = 8;
  localparam int AGE_W     = 16;
  localparam int FAULT_W   = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd1;

  localparam logic OP_REF   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  // command from the sequencer to the frame store
  typedef struct packed {
    logic              clear;
    logic [IDX_W-1:0]  addr;
    logic              page_we;
    logic [PAGE_W-1:0] page;
    logic              age_we;
    logic [AGE_W-1:0]  age;
  } frm_cmd_t;

  // frame store read port
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic [AGE_W-1:0]  age;
  } frm_rd_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   slot;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] fault_total;
  } result_t;

endpackage

// ===== src/prl_frames.sv =====
// ----------------------------------------------------------------------------
// prl_frames
// frame store: resident pages, valid bits and ages, one access port
// ----------------------------------------------------------------------------
module prl_frames import prl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  frm_cmd_t cmd,
  output frm_rd_t  rd
);

  logic [FRAMES-1:0]             valid;
  logic [FRAMES-1:0][PAGE_W-1:0] page_mem;
  logic [FRAMES-1:0][AGE_W-1:0]  age_mem;

  assign rd.valid = valid[cmd.addr];
  assign rd.page  = page_mem[cmd.addr];
  assign rd.age   = age_mem[cmd.addr];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid   <= '0;
      age_mem <= '0;
    end else begin
      if (cmd.page_we) begin
        valid[cmd.addr] <= 1'b1;
      end
      if (cmd.age_we) begin
        age_mem[cmd.addr] <= cmd.age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.page_we) begin
      page_mem[cmd.addr] <= cmd.page;
    end
  end

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.page_we && !cmd.clear |=> valid[$past(cmd.addr)])
    else $error("frame written but not marked valid");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> valid == '0 && age_mem == '0)
    else $error("clear left frames occupied or aged");

endmodule

// ===== src/prl_seq.sv =====
// ----------------------------------------------------------------------------
// prl_seq
// sequencer: scans frames one per cycle with a shared compare unit,
// places the page on a fault and walks the ages in lru mode
// ----------------------------------------------------------------------------
module prl_seq import prl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [PAGE_W-1:0] page_number,
  input  logic              policy_mode,
  input  logic [CFG_W-1:0]  frame_count,
  input  logic              out_free,
  input  frm_rd_t           rd,
  output frm_cmd_t          cmd,
  output logic              done,
  output result_t           res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_EVICT  = 5'b00100,
    S_AGE    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   n;
  logic               mode;
  logic [PAGE_W-1:0]  page;
  logic [IDX_W-1:0]   slot;
  logic [AGE_W-1:0]   best_age;
  logic [IDX_W-1:0]   best_idx;
  logic               found;
  logic               ev_valid;
  logic [PAGE_W-1:0]  ev_page;
  logic [FAULT_W-1:0] fault_counter;
  logic [IDX_W-1:0]   fifo_ptr;

  logic               accept;
  logic               last;
  logic               match;
  logic               lru_take;
  logic [IDX_W-1:0]   lru_idx;
  logic [IDX_W-1:0]   fifo_victim;
  logic [CNT_W-1:0]   victim_inc;
  logic [IDX_W-1:0]   fifo_ptr_next;
  logic [CNT_W-1:0]   n_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign done     = (state == S_DONE) && out_free;

  // frames in use, clamped to 1..FRAMES
  assign n_next = (frame_count == '0) ? CNT_W'(1) :
                  (CNT_W'(frame_count) > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) :
                  CNT_W'(frame_count);

  assign last  = (CNT_W'(idx) + CNT_W'(1)) == n;
  assign match = rd.valid && (rd.page == page);

  // running maximum of ages, ties stay at the lower index
  assign lru_take = (idx == '0) || (rd.age > best_age);
  assign lru_idx  = lru_take ? idx : best_idx;

  assign fifo_victim   = (CNT_W'(fifo_ptr) < n) ? fifo_ptr : '0;
  assign victim_inc    = CNT_W'(fifo_victim) + CNT_W'(1);
  assign fifo_ptr_next = (victim_inc >= n) ? '0 : victim_inc[IDX_W-1:0];

  always_comb begin
    cmd.clear   = accept && (opcode == OP_CLEAR);
    cmd.addr    = (state == S_EVICT) ? slot : idx;
    cmd.page_we = (state == S_EVICT);
    cmd.page    = page;
    cmd.age_we  = (state == S_AGE);
    if (idx == slot) begin
      cmd.age = '0;
    end else if (rd.age == AGE_MAX) begin
      cmd.age = rd.age;
    end else begin
      cmd.age = rd.age + AGE_W'(1);
    end
  end

  assign res.hit         = found;
  assign res.slot        = slot;
  assign res.ev_valid    = ev_valid;
  assign res.ev_page     = ev_page;
  assign res.fault_total = fault_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fault_counter <= '0;
      fifo_ptr      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx      <= '0;
            page     <= page_number;
            mode     <= policy_mode;
            n        <= n_next;
            found    <= 1'b0;
            slot     <= '0;
            ev_valid <= 1'b0;
            ev_page  <= '0;
            if (opcode == OP_CLEAR) begin
              fault_counter <= '0;
              fifo_ptr      <= '0;
              state         <= S_DONE;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (match) begin
            found <= 1'b1;
            slot  <= idx;
            idx   <= '0;
            state <= (mode == MODE_LRU) ? S_AGE : S_DONE;
          end else begin
            if (lru_take) begin
              best_age <= rd.age;
              best_idx <= idx;
            end
            if (last) begin
              if (fault_counter != FAULT_MAX) begin
                fault_counter <= fault_counter + FAULT_W'(1);
              end
              if (mode == MODE_LRU) begin
                slot <= lru_idx;
              end else begin
                slot     <= fifo_victim;
                fifo_ptr <= fifo_ptr_next;
              end
              state <= S_EVICT;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_EVICT: begin
          ev_valid <= rd.valid;
          ev_page  <= rd.valid ? rd.page : '0;
          idx      <= '0;
          state    <= (mode == MODE_LRU) ? S_AGE : S_DONE;
        end
        S_AGE: begin
          if (last) begin
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH || state == S_AGE) |-> CNT_W'(idx) < n)
    else $error("frame scan beyond frames in use");

  a_fault_no_drop: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> fault_counter >= $past(fault_counter))
    else $error("fault count fell outside a clear");

  a_done_frees_input: assert property (@(posedge clk) disable iff (rst)
    done |=> !in_stall)
    else $error("sequencer did not return to idle after a result");

endmodule

// ===== src/page_replacement_fifo_lru.sv =====
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru
// fifo / lru page replacement over a small fully associative frame table
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_stall   opcode, page_number
//  output    out_valid / out_stall hit, slot_index, evicted_valid,
//                                  evicted_page, fault_total
//  config    cfg_write             cfg_index, cfg_data
//
//  a clear empties the table when it is taken; a reference scans one frame per
//  cycle through a single compare unit up to the first match; on a fault the
//  victim frame is written; lru mode then updates the ages of all frames in use
//  in_stall is high from the cycle after a word is taken until its result
//  is loaded into the output register, which holds it while out_stall is high
//  synchronous reset empties the table and zeroes ages, pointer and fault count
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru import prl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [PAGE_W-1:0]    page_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [IDX_W-1:0]     slot_index,
  output logic                 evicted_valid,
  output logic [PAGE_W-1:0]    evicted_page,
  output logic [FAULT_W-1:0]   fault_total,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic             policy_mode;
  logic [CFG_W-1:0] frame_count;
  logic             out_free;
  logic             done;
  result_t          res;
  frm_cmd_t         cmd;
  frm_rd_t          rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= MODE_FIFO;
      frame_count <= CFG_W'(FRAMES);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POLICY: policy_mode <= cfg_data[0];
        REG_FRAMES: frame_count <= cfg_data;
        default: ;
      endcase
    end
  end

  prl_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .page_number (page_number),
    .policy_mode (policy_mode),
    .frame_count (frame_count),
    .out_free    (out_free),
    .rd          (rd),
    .cmd         (cmd),
    .done        (done),
    .res         (res)
  );

  prl_frames u_frames (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rd  (rd)
  );

  // output word register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      hit           <= res.hit;
      slot_index    <= res.slot;
      evicted_valid <= res.ev_valid;
      evicted_page  <= res.ev_page;
      fault_total   <= res.fault_total;
    end
  end

endmodule

// ===== verif/tb_page_replacement_fifo_lru.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_replacement_fifo_lru
// self-checking bench for the fifo / lru frame table: every accepted word is
// run through a local copy of the table, and each result word is compared
// field by field against the oldest prediction still outstanding
// ----------------------------------------------------------------------------
module tb_page_replacement_fifo_lru;
  import prl_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 opcode;
  logic [PAGE_W-1:0]    page_number;
  logic                 out_valid;
  logic                 out_stall;
  logic                 hit;
  logic [IDX_W-1:0]     slot_index;
  logic                 evicted_valid;
  logic [PAGE_W-1:0]    evicted_page;
  logic [FAULT_W-1:0]   fault_total;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  page_replacement_fifo_lru u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .slot_index    (slot_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // local copy of the frame table
  logic [PAGE_W-1:0]  frame_page [FRAMES];
  logic               frame_used [FRAMES];
  logic [AGE_W-1:0]   frame_age  [FRAMES];
  int                 fifo_ptr;
  logic [FAULT_W-1:0] fault_cnt;
  logic               policy_reg;
  logic [CFG_W-1:0]   frames_reg;

  result_t pending_results[$];
  int      err_count;
  int      sent_count;
  int      checked_count;
  int      send_idle_pct;
  int      rcv_stall_pct;
  int      hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("[page_replacement_fifo_lru] ERROR");
    $finish;
  end

  function automatic void empty_frames();
    for (int i = 0; i < FRAMES; i++) begin
      frame_page[i] = '0;
      frame_used[i] = 1'b0;
      frame_age[i]  = '0;
    end
    fifo_ptr  = 0;
    fault_cnt = '0;
  endfunction

  function automatic result_t predict_access(input logic op, input logic [PAGE_W-1:0] pg);
    result_t          r;
    int               n;
    int               slot;
    bit               found;
    logic [AGE_W-1:0] oldest;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    n = (frames_reg == 0) ? 1 : (frames_reg > FRAMES) ? FRAMES : int'(frames_reg);
    if (op == OP_CLEAR) begin
      empty_frames();
      return r;
    end
    // lowest matching frame wins
    for (int i = 0; i < n; i++) begin
      if (!found && frame_used[i] && frame_page[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (fault_cnt != FAULT_MAX)
        fault_cnt++;
      if (policy_reg == MODE_FIFO) begin
        slot     = (fifo_ptr < n) ? fifo_ptr : 0;
        fifo_ptr = (slot + 1 >= n) ? 0 : slot + 1;
      end else begin
        oldest = frame_age[0];
        for (int i = 1; i < n; i++) begin
          if (frame_age[i] > oldest) begin
            oldest = frame_age[i];
            slot   = i;
          end
        end
      end
      if (frame_used[slot]) begin
        r.ev_valid = 1'b1;
        r.ev_page  = frame_page[slot];
      end
      frame_page[slot] = pg;
      frame_used[slot] = 1'b1;
    end
    if (policy_reg == MODE_LRU) begin
      for (int i = 0; i < n; i++) begin
        if (i == slot)
          frame_age[i] = '0;
        else if (frame_age[i] != AGE_MAX)
          frame_age[i]++;
      end
    end
    r.hit         = found;
    r.slot        = slot[IDX_W-1:0];
    r.fault_total = fault_cnt;
    return r;
  endfunction

  task automatic report_err(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  // result side: random or held-off stall, changed on the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_err("result word with nothing outstanding");
      end else begin
        e = pending_results.pop_front();
        checked_count++;
        if (hit !== e.hit)
          report_err($sformatf("hit %0b, want %0b", hit, e.hit));
        if (slot_index !== e.slot)
          report_err($sformatf("slot_index %0d, want %0d", slot_index, e.slot));
        if (evicted_valid !== e.ev_valid)
          report_err($sformatf("evicted_valid %0b, want %0b", evicted_valid, e.ev_valid));
        if (evicted_page !== e.ev_page)
          report_err($sformatf("evicted_page %0h, want %0h", evicted_page, e.ev_page));
        if (fault_total !== e.fault_total)
          report_err($sformatf("fault_total %0d, want %0d", fault_total, e.fault_total));
      end
    end
  end

  task automatic send_word(input logic op, input logic [PAGE_W-1:0] pg);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    page_number <= pg;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_access(op, pg));
    sent_count++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let the design sit idle between phases
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_POLICY)
      policy_reg = data[0];
    else
      frames_reg = data;
  endtask

  task automatic set_policy(input logic mode);
    // upper data bits are don't-care for the policy register
    write_reg(REG_POLICY, {3'($urandom_range(7)), mode});
  endtask

  task automatic test_fifo_directed();
    send_word(OP_REF, 8'h00);
    send_word(OP_REF, 8'hFF);
    send_word(OP_REF, 8'h00);
    for (int p = 1; p <= 6; p++)
      send_word(OP_REF, PAGE_W'(p));
    // table full: next fault evicts frame 0
    send_word(OP_REF, 8'h77);
    send_word(OP_CLEAR, 8'hC3);
    send_word(OP_REF, 8'hFF);
  endtask

  task automatic test_frame_limits();
    write_reg(REG_FRAMES, 4'd0);
    send_word(OP_REF, 8'h10);
    send_word(OP_REF, 8'h11);
    write_reg(REG_FRAMES, 4'd15);
    send_word(OP_REF, 8'h11);
  endtask

  task automatic test_pointer_shrink();
    write_reg(REG_FRAMES, 4'd8);
    send_word(OP_CLEAR, 8'h00);
    for (int p = 0; p < 3; p++)
      send_word(OP_REF, PAGE_W'(8'h20 + p));
    // pointer now past the frames in use
    write_reg(REG_FRAMES, 4'd2);
    send_word(OP_REF, 8'h30);
    // frame 2 is outside the search range, so this faults
    send_word(OP_REF, 8'h22);
    write_reg(REG_FRAMES, 4'd8);
    send_word(OP_REF, 8'h22);
  endtask

  task automatic test_lru_directed();
    set_policy(MODE_LRU);
    write_reg(REG_FRAMES, 4'd4);
    send_word(OP_CLEAR, 8'h00);
    for (int p = 1; p <= 4; p++)
      send_word(OP_REF, PAGE_W'(p));
    send_word(OP_REF, 8'h01);
    send_word(OP_REF, 8'h05);
    send_word(OP_REF, 8'h03);
  endtask

  // keep hitting frame 0 so the other ages climb while it stays youngest
  task automatic test_age_growth();
    set_policy(MODE_LRU);
    write_reg(REG_FRAMES, 4'd3);
    send_word(OP_CLEAR, 8'h00);
    send_word(OP_REF, 8'hA0);
    send_word(OP_REF, 8'hA1);
    send_word(OP_REF, 8'hA2);
    for (int i = 0; i < 20; i++)
      send_word(OP_REF, 8'hA0);
    send_word(OP_REF, 8'hA3);
  endtask

  task automatic test_output_holdoff();
    set_policy(MODE_FIFO);
    write_reg(REG_FRAMES, 4'd8);
    send_word(OP_REF, 8'h40);
    hold_left = 300;
    for (int i = 0; i < 8; i++)
      send_word(OP_REF, PAGE_W'($urandom_range(8'h40, 8'h4A)));
  endtask

  task automatic run_random(input int count);
    logic [PAGE_W-1:0] base;
    base = PAGE_W'($urandom_range(255));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3)
        send_word(OP_CLEAR, PAGE_W'($urandom_range(255)));
      else if ($urandom_range(99) < 75)
        send_word(OP_REF, base + PAGE_W'($urandom_range(11)));
      else
        send_word(OP_REF, PAGE_W'($urandom_range(255)));
    end
  endtask

  task automatic test_random();
    int          send_pct [4] = '{0, 85, 0, 18};
    int          rcv_pct  [4] = '{0, 0, 85, 18};
    logic        modes    [8] = '{MODE_FIFO, MODE_LRU, MODE_LRU, MODE_FIFO,
                                  MODE_LRU, MODE_FIFO, MODE_LRU, MODE_FIFO};
    logic [3:0]  counts   [8] = '{4'd8, 4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd12};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct[ph];
      rcv_stall_pct = rcv_pct[ph];
      for (int s = 0; s < 2; s++) begin
        set_policy(modes[2 * ph + s]);
        write_reg(REG_FRAMES, counts[2 * ph + s]);
        run_random(72);
      end
    end
    send_idle_pct = 0;
    rcv_stall_pct = 0;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_REF;
    page_number   = '0;
    cfg_write     = 1'b0;
    cfg_index     = REG_POLICY;
    cfg_data      = '0;
    err_count     = 0;
    sent_count    = 0;
    checked_count = 0;
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_left     = 0;
    policy_reg    = MODE_FIFO;
    frames_reg    = 4'd8;
    empty_frames();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_fifo_directed();
    test_frame_limits();
    test_pointer_shrink();
    test_lru_directed();
    test_age_growth();
    test_output_holdoff();
    test_random();

    wait_drain();
    repeat (40) @(posedge clk);
    $display("sent %0d words, checked %0d results: fifo and lru, frame counts 0..15,",
             sent_count, checked_count);
    $display("pointer past shrunk table, age growth, long output hold-off; %0d mismatches",
             err_count);
    if (err_count == 0)
      $display("[page_replacement_fifo_lru] OK");
    else
      $display("[page_replacement_fifo_lru] ERROR");
    $finish;
  end

endmodule
